// ===== src/pic_pkg.sv =====
// Shared types and constants for the point-in-cylinder test pipeline.
// No dependencies; pic_cfg, pic_geom, pic_decide and the top refer to it by scoped names.
package pic_pkg;

  localparam int CoordW = 16;
  localparam int LenW   = 15;
  localparam int IdxW   = 4;

  localparam logic [IdxW-1:0] REG_END_A_X   = 4'd0;
  localparam logic [IdxW-1:0] REG_END_A_Y   = 4'd1;
  localparam logic [IdxW-1:0] REG_END_A_Z   = 4'd2;
  localparam logic [IdxW-1:0] REG_END_B_X   = 4'd3;
  localparam logic [IdxW-1:0] REG_END_B_Y   = 4'd4;
  localparam logic [IdxW-1:0] REG_END_B_Z   = 4'd5;
  localparam logic [IdxW-1:0] REG_RADIUS    = 4'd6;
  localparam logic [IdxW-1:0] REG_TOLERANCE = 4'd7;

  // one unit of the axial parameter in Q.4
  localparam logic [15:0] AXIAL_ONE = 16'd16;

  typedef struct packed {
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [16:0] d_x;
    logic signed [16:0] d_y;
    logic signed [16:0] d_z;
    logic [48:0]        tol_h2;
    logic [49:0]        tol16_h2;
    logic [65:0]        rad_h2;
    logic               degen;
  } cyl_cfg_t;

  typedef struct packed {
    logic signed [34:0] dot;
    logic [32:0]        mag_x;
    logic [32:0]        mag_y;
    logic [32:0]        mag_z;
  } geom_t;

endpackage

// ===== src/pic_in_if.sv =====
// Query point channel: valid/ready handshake with three Q11.4 coordinates.
// Depends on nothing.
interface pic_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                output ready);
endinterface

// ===== src/pic_out_if.sv =====
// Result channel: valid/ready handshake with the inside and degenerate flags.
// Depends on nothing.
interface pic_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic degenerate_axis;

  modport source (output valid, output inside_res, output degenerate_axis, input ready);
  modport sink (input valid, input inside_res, input degenerate_axis, output ready);
endinterface

// ===== src/pic_cfg.sv =====
// Configuration registers and the cylinder values derived from them.
// Depends on pic_pkg. Derived values settle through the difference, square, sum and product registers after a write.
module pic_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [pic_pkg::IdxW-1:0]  cfg_idx,
  input  logic [pic_pkg::CoordW-1:0] cfg_wdata,
  output pic_pkg::cyl_cfg_t         cfg
);

  logic signed [15:0] a_x_r, a_y_r, a_z_r, b_x_r, b_y_r, b_z_r;
  logic [14:0]        rad_r, tol_r;

  logic signed [16:0] d_x_r, d_y_r, d_z_r;
  logic [15:0]        rs_r, tol16_r;
  logic [31:0]        sq_x_r, sq_y_r, sq_z_r, rs2_r;
  logic [33:0]        h2_r;
  logic [48:0]        tol_h2_r;
  logic [49:0]        tol16_h2_r;
  logic [65:0]        rad_h2_r;
  logic               degen_r;

  logic signed [33:0] sq_x_full, sq_y_full, sq_z_full;
  logic [31:0]        sq_x_nxt, sq_y_nxt, sq_z_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_x_r <= '0;
      a_y_r <= '0;
      a_z_r <= '0;
      b_x_r <= '0;
      b_y_r <= '0;
      b_z_r <= '0;
      rad_r <= '0;
      tol_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        pic_pkg::REG_END_A_X:   a_x_r <= cfg_wdata;
        pic_pkg::REG_END_A_Y:   a_y_r <= cfg_wdata;
        pic_pkg::REG_END_A_Z:   a_z_r <= cfg_wdata;
        pic_pkg::REG_END_B_X:   b_x_r <= cfg_wdata;
        pic_pkg::REG_END_B_Y:   b_y_r <= cfg_wdata;
        pic_pkg::REG_END_B_Z:   b_z_r <= cfg_wdata;
        pic_pkg::REG_RADIUS:    rad_r <= cfg_wdata[14:0];
        pic_pkg::REG_TOLERANCE: tol_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sq_x_full = 34'(d_x_r) * 34'(d_x_r);
    sq_y_full = 34'(d_y_r) * 34'(d_y_r);
    sq_z_full = 34'(d_z_r) * 34'(d_z_r);
    sq_x_nxt  = sq_x_full[31:0];
    sq_y_nxt  = sq_y_full[31:0];
    sq_z_nxt  = sq_z_full[31:0];
  end

  always_ff @(posedge clk) begin
    d_x_r      <= 17'(b_x_r) - 17'(a_x_r);
    d_y_r      <= 17'(b_y_r) - 17'(a_y_r);
    d_z_r      <= 17'(b_z_r) - 17'(a_z_r);
    rs_r       <= 16'(rad_r) + 16'(tol_r);
    tol16_r    <= 16'(tol_r) + pic_pkg::AXIAL_ONE;
    sq_x_r     <= sq_x_nxt;
    sq_y_r     <= sq_y_nxt;
    sq_z_r     <= sq_z_nxt;
    rs2_r      <= 32'(rs_r) * 32'(rs_r);
    h2_r       <= 34'(sq_x_r) + 34'(sq_y_r) + 34'(sq_z_r);
    tol_h2_r   <= 49'(tol_r) * 49'(h2_r);
    tol16_h2_r <= 50'(tol16_r) * 50'(h2_r);
    rad_h2_r   <= 66'(rs2_r) * 66'(h2_r);
    degen_r    <= (h2_r == '0);
  end

  always_comb begin
    cfg.a_x      = a_x_r;
    cfg.a_y      = a_y_r;
    cfg.a_z      = a_z_r;
    cfg.d_x      = d_x_r;
    cfg.d_y      = d_y_r;
    cfg.d_z      = d_z_r;
    cfg.tol_h2   = tol_h2_r;
    cfg.tol16_h2 = tol16_h2_r;
    cfg.rad_h2   = rad_h2_r;
    cfg.degen    = degen_r;
  end

endmodule

// ===== src/pic_geom.sv =====
// Front half of the pipeline: offset from end A, nine products, dot and cross.
// Depends on pic_pkg and pic_in_if; three stages, each occupied one holds on a stall.
module pic_geom (
  input  logic              clk,
  input  logic              rst_n,
  pic_in_if.sink            in_pt,
  input  pic_pkg::cyl_cfg_t cfg,
  output logic              g_valid,
  input  logic              g_ready,
  output pic_pkg::geom_t    g
);

  function automatic logic [32:0] mag33(input logic signed [33:0] v);
    logic signed [33:0] n;
    n = -v;
    return v[33] ? n[32:0] : v[32:0];
  endfunction

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  logic signed [16:0] q_x_r, q_y_r, q_z_r;
  logic signed [32:0] p_xdx_r, p_ydy_r, p_zdz_r;
  logic signed [32:0] p_ydz_r, p_zdy_r, p_zdx_r, p_xdz_r, p_xdy_r, p_ydx_r;
  pic_pkg::geom_t     g_r, g_nxt;

  logic signed [33:0] c_x, c_y, c_z;

  assign en3 = !v3_r || g_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_pt.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_pt.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_comb begin
    c_x         = 34'(p_ydz_r) - 34'(p_zdy_r);
    c_y         = 34'(p_zdx_r) - 34'(p_xdz_r);
    c_z         = 34'(p_xdy_r) - 34'(p_ydx_r);
    g_nxt.dot   = 35'(p_xdx_r) + 35'(p_ydy_r) + 35'(p_zdz_r);
    g_nxt.mag_x = mag33(c_x);
    g_nxt.mag_y = mag33(c_y);
    g_nxt.mag_z = mag33(c_z);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      q_x_r <= 17'(in_pt.point_x) - 17'(cfg.a_x);
      q_y_r <= 17'(in_pt.point_y) - 17'(cfg.a_y);
      q_z_r <= 17'(in_pt.point_z) - 17'(cfg.a_z);
    end
    if (en2) begin
      p_xdx_r <= 33'(q_x_r) * 33'(cfg.d_x);
      p_ydy_r <= 33'(q_y_r) * 33'(cfg.d_y);
      p_zdz_r <= 33'(q_z_r) * 33'(cfg.d_z);
      p_ydz_r <= 33'(q_y_r) * 33'(cfg.d_z);
      p_zdy_r <= 33'(q_z_r) * 33'(cfg.d_y);
      p_zdx_r <= 33'(q_z_r) * 33'(cfg.d_x);
      p_xdz_r <= 33'(q_x_r) * 33'(cfg.d_z);
      p_xdy_r <= 33'(q_x_r) * 33'(cfg.d_y);
      p_ydx_r <= 33'(q_y_r) * 33'(cfg.d_x);
    end
    if (en3) g_r <= g_nxt;
  end

  assign g_valid = v3_r;
  assign g       = g_r;

endmodule

// ===== src/pic_decide.sv =====
// Back half of the pipeline: cross squares, axial window, radial compare.
// Depends on pic_pkg and pic_out_if; the last stage is the output register.
module pic_decide (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              g_valid,
  output logic              g_ready,
  input  pic_pkg::geom_t    g,
  input  pic_pkg::cyl_cfg_t cfg,
  pic_out_if.source         out_res
);

  logic v4_r, v5_r, v6_r;
  logic en4, en5, en6;

  logic [65:0]        sq_x_r, sq_y_r, sq_z_r;
  logic signed [34:0] dot_r;
  logic [67:0]        lhs_r;
  logic               axial_r;
  logic               inside_r, degen_r;

  logic signed [50:0] dot16, low_sum;
  logic               axial_nxt;

  assign en6 = !v6_r || out_res.ready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign g_ready = en4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en4) v4_r <= g_valid;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  always_comb begin
    dot16     = 51'($signed({dot_r, 4'b0000}));
    low_sum   = dot16 + $signed({2'b00, cfg.tol_h2});
    axial_nxt = !low_sum[50] && (dot16 <= $signed({1'b0, cfg.tol16_h2}));
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      sq_x_r <= 66'(g.mag_x) * 66'(g.mag_x);
      sq_y_r <= 66'(g.mag_y) * 66'(g.mag_y);
      sq_z_r <= 66'(g.mag_z) * 66'(g.mag_z);
      dot_r  <= g.dot;
    end
    if (en5) begin
      lhs_r   <= 68'(sq_x_r) + 68'(sq_y_r) + 68'(sq_z_r);
      axial_r <= axial_nxt;
    end
    if (en6) begin
      inside_r <= !cfg.degen && axial_r && (lhs_r <= {2'b00, cfg.rad_h2});
      degen_r  <= cfg.degen;
    end
  end

  assign out_res.valid           = v6_r;
  assign out_res.inside_res      = inside_r;
  assign out_res.degenerate_axis = degen_r;

endmodule

// ===== src/point_in_cylinder_test_core.sv =====
// Top level of the point-in-finite-cylinder test.
// Depends on pic_pkg, pic_in_if, pic_out_if, pic_cfg, pic_geom, pic_decide.
//
//   channel   direction  payload                          handshake
//   in_pt     in         point_x, point_y, point_z        valid/ready
//   out_res   out        inside_res, degenerate_axis      valid/ready
//   cfg_*     in         cfg_idx, cfg_wdata               cfg_we, write only
//
// Six register stages, from the offset stage to the output register; one point
// transfers every cycle while the result side takes them.
// Derived values settle via the difference, square, sum and product registers.
// Synchronous reset clears the registers and every stage valid bit.
// A stall holds each occupied stage; empty stages keep filling.
module point_in_cylinder_test_core (
  input  logic                       clk,
  input  logic                       rst_n,
  pic_in_if.sink                     in_pt,
  pic_out_if.source                  out_res,
  input  logic                       cfg_we,
  input  logic [pic_pkg::IdxW-1:0]   cfg_idx,
  input  logic [pic_pkg::CoordW-1:0] cfg_wdata
);

  pic_pkg::cyl_cfg_t cfg;
  pic_pkg::geom_t    g;
  logic              g_valid;
  logic              g_ready;

  pic_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pic_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pt   (in_pt),
    .cfg     (cfg),
    .g_valid (g_valid),
    .g_ready (g_ready),
    .g       (g)
  );

  pic_decide u_decide (
    .clk     (clk),
    .rst_n   (rst_n),
    .g_valid (g_valid),
    .g_ready (g_ready),
    .g       (g),
    .cfg     (cfg),
    .out_res (out_res)
  );

endmodule
